// ===== design/stcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcd_pkg
// Shared types, constants and helpers of the STUN / ChannelData TCP deframer.
// ----------------------------------------------------------------------------
package stcd_pkg;

    localparam int MAX_HEADER  = 20;
    localparam int MIN_HEADER  = 8;
    localparam int HDR_CNT_W   = $clog2(MAX_HEADER + 1);
    localparam int HDR_IDX_W   = $clog2(MAX_HEADER);

    localparam int HLEN_W      = 5;
    localparam int BODY_LEN_W  = 16;
    localparam int REM_W       = 17;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0]           STUN_COOKIE  = 32'h2112A442;
    localparam logic [REM_W-1:0]      STUN_EXTRA   = 17'd12;
    localparam logic [BODY_LEN_W-1:0] CHAN_HDR     = 16'd4;
    localparam logic [REM_W-1:0]      PAD_ROUND    = 17'd3;

    localparam logic [HLEN_W-1:0]     RESET_HEADER_LENGTH = 5'd8;
    localparam logic [BODY_LEN_W-1:0] RESET_MAX_BODY      = 16'd1500;

    localparam logic [CFG_IDX_W-1:0]  CFG_HEADER_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_MAX_BODY      = 1'b1;

    typedef enum logic [1:0] {
        PH_COLLECT,
        PH_CLASSIFY,
        PH_EMIT,
        PH_BODY
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       frame_error;
        logic       is_stun;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result item;
    } t_push;

    typedef struct packed {
        logic [HLEN_W-1:0]     header_length;
        logic [BODY_LEN_W-1:0] max_body_length;
    } t_cfg;

    function automatic logic [HDR_CNT_W-1:0] eff_header_len(input logic [HLEN_W-1:0] hl);
        int h;
        h = int'(hl);
        if (h < MIN_HEADER) begin
            h = MIN_HEADER;
        end
        if (h > MAX_HEADER) begin
            h = MAX_HEADER;
        end
        return HDR_CNT_W'(h);
    endfunction

endpackage

// ===== design/stcd_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcd interfaces
// Valid/ready channels for stream bytes, result beats and register writes.
// ----------------------------------------------------------------------------
interface stcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface stcd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    logic       frame_error;
    logic       is_stun;

    modport source (output valid, output data_byte, output last, output frame_error,
                    output is_stun, input ready);
    modport sink   (input valid, input data_byte, input last, input frame_error,
                    input is_stun, output ready);
endinterface

interface stcd_cfg_if import stcd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/stcd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcd_queue
// Short result queue between the front end and the output channel.
// ----------------------------------------------------------------------------
module stcd_queue
    import stcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_push             i_push,
    output logic              o_full,
    stcd_res_if.source        o_res
);

    t_result                r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic                   pop;
    logic                   push;
    t_result                head;

    assign o_full = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push   = i_push.valid && !o_full;
    assign pop    = o_res.valid && o_res.ready;
    assign head   = r_mem[r_rd_ptr];

    assign o_res.valid       = (r_cnt != '0);
    assign o_res.data_byte   = head.data_byte;
    assign o_res.last        = head.last;
    assign o_res.frame_error = head.frame_error;
    assign o_res.is_stun     = head.is_stun;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + QUEUE_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QUEUE_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/stcd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcd_front
// Collects the frame header, classifies STUN or ChannelData, checks the body
// length and feeds header, body and error beats to the result queue.
// ----------------------------------------------------------------------------
module stcd_front
    import stcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    stcd_byte_if.sink  i_in,
    input  t_cfg       i_cfg,
    input  logic       i_q_full,
    output t_push      o_push
);

    t_phase                r_phase, n_phase;
    logic [HDR_CNT_W-1:0]  r_count, n_count;
    logic [HDR_CNT_W-1:0]  r_hlen,  n_hlen;
    logic                  r_kind,  n_kind;
    logic [REM_W-1:0]      r_deliver_rem, n_deliver_rem;
    logic [REM_W-1:0]      r_body_rem,    n_body_rem;
    logic [7:0]            r_hdr [MAX_HEADER];

    logic                  in_acc;
    logic [HDR_CNT_W-1:0]  eff_h;
    logic [HDR_CNT_W-1:0]  count_inc;
    logic [BODY_LEN_W-1:0] len16;
    logic [31:0]           cookie;
    logic                  stun;
    logic [REM_W-1:0]      deliver;
    logic [REM_W-1:0]      total;

    assign in_acc    = i_in.valid && i_in.ready;
    assign eff_h     = eff_header_len(i_cfg.header_length);
    assign count_inc = r_count + HDR_CNT_W'(1);
    assign len16     = {r_hdr[2], r_hdr[3]};
    assign cookie    = {r_hdr[4], r_hdr[5], r_hdr[6], r_hdr[7]};
    assign stun      = (cookie == STUN_COOKIE);

    always_comb begin
        if (stun) begin
            deliver = REM_W'(len16) + STUN_EXTRA;
            total   = deliver;
        end else begin
            deliver = REM_W'(len16 - CHAN_HDR);
            total   = (deliver + PAD_ROUND) & ~PAD_ROUND;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_count       = r_count;
        n_hlen        = r_hlen;
        n_kind        = r_kind;
        n_deliver_rem = r_deliver_rem;
        n_body_rem    = r_body_rem;
        i_in.ready    = 1'b0;
        o_push        = '0;
        unique case (r_phase)
            PH_COLLECT: begin
                i_in.ready = 1'b1;
                if (in_acc) begin
                    n_count = count_inc;
                    if (count_inc >= eff_h) begin
                        n_phase = PH_CLASSIFY;
                        n_count = '0;
                        n_hlen  = eff_h;
                    end
                end
            end
            PH_CLASSIFY: begin
                if (!i_q_full) begin
                    n_kind = stun;
                    if (!stun && (len16 < CHAN_HDR)) begin
                        o_push.valid = 1'b1;
                        o_push.item  = '{data_byte: 8'd0, last: 1'b1,
                                         frame_error: 1'b1, is_stun: 1'b0};
                        n_phase      = PH_COLLECT;
                    end else if (total > REM_W'(i_cfg.max_body_length)) begin
                        o_push.valid = 1'b1;
                        o_push.item  = '{data_byte: 8'd0, last: 1'b1,
                                         frame_error: 1'b1, is_stun: stun};
                        n_phase      = PH_COLLECT;
                    end else begin
                        n_deliver_rem = deliver;
                        n_body_rem    = total;
                        n_phase       = PH_EMIT;
                    end
                end
            end
            PH_EMIT: begin
                if (!i_q_full) begin
                    o_push.valid = 1'b1;
                    o_push.item  = '{data_byte: r_hdr[r_count[HDR_IDX_W-1:0]],
                                     last: (r_deliver_rem == '0) && (count_inc == r_hlen),
                                     frame_error: 1'b0, is_stun: r_kind};
                    n_count = count_inc;
                    if (count_inc == r_hlen) begin
                        n_count = '0;
                        n_phase = (r_body_rem == '0) ? PH_COLLECT : PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                i_in.ready = !i_q_full;
                if (in_acc) begin
                    if (r_deliver_rem != '0) begin
                        o_push.valid  = 1'b1;
                        o_push.item   = '{data_byte: i_in.in_byte,
                                          last: (r_deliver_rem == REM_W'(1)),
                                          frame_error: 1'b0, is_stun: r_kind};
                        n_deliver_rem = r_deliver_rem - REM_W'(1);
                    end
                    n_body_rem = r_body_rem - REM_W'(1);
                    if (r_body_rem == REM_W'(1)) begin
                        n_phase       = PH_COLLECT;
                        n_count       = '0;
                        n_deliver_rem = '0;
                    end
                end
            end
            default: begin
                n_phase = PH_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (r_phase == PH_COLLECT) && (r_count < HDR_CNT_W'(MAX_HEADER))) begin
            r_hdr[r_count[HDR_IDX_W-1:0]] <= i_in.in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_COLLECT;
            r_count       <= '0;
            r_hlen        <= HDR_CNT_W'(MIN_HEADER);
            r_kind        <= 1'b0;
            r_deliver_rem <= '0;
            r_body_rem    <= '0;
        end else begin
            r_phase       <= n_phase;
            r_count       <= n_count;
            r_hlen        <= n_hlen;
            r_kind        <= n_kind;
            r_deliver_rem <= n_deliver_rem;
            r_body_rem    <= n_body_rem;
        end
    end

endmodule

// ===== design/stun_channeldata_tcp_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stun_channeldata_tcp_deframer
// Splits a TCP byte stream into STUN messages and TURN ChannelData frames.
// ----------------------------------------------------------------------------
// Channels: i_in carries one stream byte per beat; o_res carries one result
// beat (data byte, last, frame_error, is_stun); i_cfg writes header_length
// (index 0) and max_body_length (index 1) and is always ready.
// Header bytes are taken one per cycle. Once header_length bytes (clamped to
// 8..20) are in, PH_CLASSIFY classifies the frame, then the header goes out
// one beat per cycle while the queue has space, and i_in is held off meanwhile.
// Body bytes are taken one per cycle while the queue has space and are pushed
// into the result queue, which feeds o_res; padding is taken and dropped.
// A short or oversize frame gives one error beat and the next header starts.
// A four-beat result queue parts the front end from o_res; a receiver stall
// fills it, and in the body phase i_in.ready then drops until space returns.
// Reset empties the queue, restarts header collection and restores the
// registers to header_length 8 and max_body_length 1500.
// ----------------------------------------------------------------------------
module stun_channeldata_tcp_deframer
    import stcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    stcd_byte_if.sink   i_in,
    stcd_cfg_if.sink    i_cfg,
    stcd_res_if.source  o_res
);

    logic [HLEN_W-1:0]     r_header_length;
    logic [BODY_LEN_W-1:0] r_max_body_length;
    t_cfg                  cfg;
    t_push                 push;
    logic                  q_full;

    assign i_cfg.ready = 1'b1;
    assign cfg = '{header_length: r_header_length, max_body_length: r_max_body_length};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_length   <= RESET_HEADER_LENGTH;
            r_max_body_length <= RESET_MAX_BODY;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_HEADER_LENGTH: r_header_length   <= i_cfg.data[HLEN_W-1:0];
                CFG_MAX_BODY:      r_max_body_length <= i_cfg.data;
                default:           r_max_body_length <= r_max_body_length;
            endcase
        end
    end

    stcd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (cfg),
        .i_q_full (q_full),
        .o_push   (push)
    );

    stcd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (q_full),
        .o_res    (o_res)
    );

`ifndef SYNTHESIS
    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> !q_full)
        else $error("result pushed into a full queue");

    a_error_beat_form : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_error) |-> (o_res.last && (o_res.data_byte == 8'd0)))
        else $error("error beat without last or with non-zero data");

    a_reset_empties : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result queue not empty after reset");

    a_no_input_while_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.ready && q_full) |-> !push.valid)
        else $error("byte taken with a result but no queue space");
`endif

endmodule

// ===== tb/sv/stcd_deframer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcd_deframer_checker
// Watches the byte, register and result channels of the deframer. It rebuilds
// the frame state from every accepted byte and register write, queues the
// result beats each byte should cause and compares each result beat with the
// oldest one queued.
// ----------------------------------------------------------------------------
module stcd_deframer_checker
    import stcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    stcd_byte_if  i_in_mon,
    stcd_cfg_if   i_cfg_mon,
    stcd_res_if   i_res_mon,
    output int    o_fail_count,
    output int    o_pending
);

    logic [HLEN_W-1:0]     hdr_len_reg;
    logic [BODY_LEN_W-1:0] max_body_reg;
    t_phase                frame_phase;
    logic [7:0]            hdr_bytes [MAX_HEADER];
    logic [4:0]            hdr_cnt;
    logic [REM_W-1:0]      body_left;
    logic [REM_W-1:0]      deliver_left;
    logic                  kind_stun;
    t_result               frame_beats_q [$];
    int                    fail_cnt = 0;

    function automatic void push_beat(input logic [7:0] d, input logic l, input logic e,
                                      input logic s);
        t_result r;
        r.data_byte   = d;
        r.last        = l;
        r.frame_error = e;
        r.is_stun     = s;
        frame_beats_q.push_back(r);
    endfunction

    task automatic predict_frame_beats(input logic [7:0] b);
        int               h;
        logic [15:0]      len16;
        logic [31:0]      cookie;
        logic [REM_W-1:0] deliver;
        logic [REM_W-1:0] total;
        logic             accepted;
        if (frame_phase == PH_BODY) begin
            if (deliver_left != '0) begin
                push_beat(b, deliver_left == REM_W'(1), 1'b0, kind_stun);
                deliver_left = deliver_left - REM_W'(1);
            end
            if (body_left != '0) begin
                body_left = body_left - REM_W'(1);
            end
            if (body_left == '0) begin
                frame_phase  = PH_COLLECT;
                hdr_cnt      = '0;
                deliver_left = '0;
            end
        end else begin
            frame_phase = PH_COLLECT;
            h = int'(hdr_len_reg);
            if (h < MIN_HEADER) begin
                h = MIN_HEADER;
            end
            if (h > MAX_HEADER) begin
                h = MAX_HEADER;
            end
            if (int'(hdr_cnt) < MAX_HEADER) begin
                hdr_bytes[hdr_cnt] = b;
            end
            if (hdr_cnt < 5'd31) begin
                hdr_cnt = hdr_cnt + 5'd1;
            end
            if (int'(hdr_cnt) >= h) begin
                hdr_cnt  = '0;
                len16    = {hdr_bytes[2], hdr_bytes[3]};
                cookie   = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
                accepted = 1'b1;
                deliver  = '0;
                total    = '0;
                if (cookie == STUN_COOKIE) begin
                    kind_stun = 1'b1;
                    deliver   = REM_W'(len16) + STUN_EXTRA;
                    total     = deliver;
                end else begin
                    kind_stun = 1'b0;
                    if (len16 < CHAN_HDR) begin
                        push_beat(8'h00, 1'b1, 1'b1, 1'b0);
                        accepted = 1'b0;
                    end else begin
                        deliver = REM_W'(len16 - CHAN_HDR);
                        total   = (deliver + PAD_ROUND) & ~PAD_ROUND;
                    end
                end
                if (accepted && total > REM_W'(max_body_reg)) begin
                    push_beat(8'h00, 1'b1, 1'b1, kind_stun);
                    accepted = 1'b0;
                end
                if (accepted) begin
                    for (int i = 0; i < h; i++) begin
                        push_beat(hdr_bytes[i], deliver == '0 && i + 1 == h, 1'b0, kind_stun);
                    end
                    body_left    = total;
                    deliver_left = deliver;
                    if (total != '0) begin
                        frame_phase = PH_BODY;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result got_beat;
        t_result want_beat;
        if (!i_rst_n) begin
            hdr_len_reg  = RESET_HEADER_LENGTH;
            max_body_reg = RESET_MAX_BODY;
            frame_phase  = PH_COLLECT;
            hdr_cnt      = '0;
            body_left    = '0;
            deliver_left = '0;
            kind_stun    = 1'b0;
            frame_beats_q.delete();
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (i_cfg_mon.index)
                    CFG_HEADER_LENGTH: hdr_len_reg  = i_cfg_mon.data[HLEN_W-1:0];
                    CFG_MAX_BODY:      max_body_reg = i_cfg_mon.data[BODY_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                predict_frame_beats(i_in_mon.in_byte);
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                got_beat.data_byte   = i_res_mon.data_byte;
                got_beat.last        = i_res_mon.last;
                got_beat.frame_error = i_res_mon.frame_error;
                got_beat.is_stun     = i_res_mon.is_stun;
                if (frame_beats_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("%0t: unexpected result beat: data %02h last %b err %b stun %b",
                                 $realtime, got_beat.data_byte, got_beat.last,
                                 got_beat.frame_error, got_beat.is_stun);
                    end
                end else begin
                    want_beat = frame_beats_q.pop_front();
                    if (got_beat !== want_beat) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("%0t: result beat mismatch: expected data %02h last %b",
                                     $realtime, want_beat.data_byte, want_beat.last,
                                     " err %b stun %b, got data %02h last %b err %b stun %b",
                                     want_beat.frame_error, want_beat.is_stun,
                                     got_beat.data_byte, got_beat.last,
                                     got_beat.frame_error, got_beat.is_stun);
                        end
                    end
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= frame_beats_q.size();
    end

endmodule

// ===== tb/sv/stun_channeldata_tcp_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stun_channeldata_tcp_deframer_tb
// Feeds the deframer STUN and ChannelData frames over several register
// settings: directed edge cases first, then random frames mixed with short,
// oversize and noise headers. Both sides idle at random, and one long result
// stall fills the block. A checker beside the block compares every beat.
// ----------------------------------------------------------------------------
module stun_channeldata_tcp_deframer_tb;
    import stcd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int IDLE_PCT      = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 2 * MAX_HEADER + 8;
    localparam int PHASE_BYTES   = 12;
    localparam int SPAN_CAP      = 64;
    localparam int CYCLE_LIMIT   = 200000;

    logic i_clk;
    logic i_rst_n;

    stcd_byte_if in_if ();
    stcd_cfg_if  cfg_if ();
    stcd_res_if  res_if ();

    int                    fail_count;
    int                    pending_beats;
    int                    cycle_cnt;
    int                    phase_bytes;
    logic [HLEN_W-1:0]     cur_hdr_len;
    logic [BODY_LEN_W-1:0] cur_max_body;
    logic [7:0]            frame_hdr [MAX_HEADER];
    logic                  calm;
    logic                  pressure_req;

    stun_channeldata_tcp_deframer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    stcd_deframer_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_if),
        .i_cfg_mon    (cfg_if),
        .i_res_mon    (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : result_sink
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (pressure_req && !held_once) begin
                res_if.ready <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                held_once = 1'b1;
            end else begin
                res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic int header_bytes();
        int h;
        h = int'(cur_hdr_len);
        if (h < MIN_HEADER) begin
            h = MIN_HEADER;
        end
        if (h > MAX_HEADER) begin
            h = MAX_HEADER;
        end
        return h;
    endfunction

    function automatic int body_span();
        int len16;
        int total;
        len16 = int'({frame_hdr[2], frame_hdr[3]});
        if ({frame_hdr[4], frame_hdr[5], frame_hdr[6], frame_hdr[7]} == STUN_COOKIE) begin
            total = len16 + int'(STUN_EXTRA);
        end else if (len16 < int'(CHAN_HDR)) begin
            total = 0;
        end else begin
            total = (len16 - int'(CHAN_HDR) + 3) / 4 * 4;
        end
        if (total > int'(cur_max_body)) begin
            total = 0;
        end
        return total;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        phase_bytes++;
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] hl_word,
                            input logic [BODY_LEN_W-1:0] max_body);
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_HEADER_LENGTH;
        cfg_if.data  <= hl_word;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.index <= CFG_MAX_BODY;
        cfg_if.data  <= max_body;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cur_hdr_len  = hl_word[HLEN_W-1:0];
        cur_max_body = max_body;
        phase_bytes  = 0;
    endtask

    task automatic send_frame(input logic [15:0] len16, input logic [31:0] word);
        int span;
        for (int i = 0; i < MAX_HEADER; i++) begin
            frame_hdr[i] = 8'($urandom);
        end
        {frame_hdr[2], frame_hdr[3]} = len16;
        {frame_hdr[4], frame_hdr[5], frame_hdr[6], frame_hdr[7]} = word;
        span = body_span();
        if (span > SPAN_CAP) begin
            frame_hdr[2] = 8'h00;
            frame_hdr[3] = 8'($urandom_range(0, 3));
            span = body_span();
        end
        for (int i = 0; i < header_bytes(); i++) begin
            put_byte(frame_hdr[i]);
        end
        for (int i = 0; i < span; i++) begin
            put_byte(8'($urandom));
        end
    endtask

    task automatic send_random_frames();
        int pick;
        int lo;
        while (phase_bytes < PHASE_BYTES) begin
            pick = $urandom_range(0, 99);
            lo   = int'(cur_max_body) > 11 ? int'(cur_max_body) - 11 : 0;
            if (pick < 40) begin
                send_frame(16'($urandom_range(0, 12)), STUN_COOKIE);
            end else if (pick < 80) begin
                send_frame(16'($urandom_range(4, 28)), $urandom);
            end else if (pick < 88) begin
                send_frame(16'($urandom_range(0, 3)), $urandom);
            end else if (pick < 94) begin
                send_frame(16'($urandom_range(lo, 65535)), STUN_COOKIE);
            end else begin
                send_frame(16'($urandom), $urandom);
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.in_byte <= 8'h00;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= CFG_HEADER_LENGTH;
        cfg_if.data   <= '0;
        calm          <= 1'b0;
        pressure_req  <= 1'b0;
        cur_hdr_len   = RESET_HEADER_LENGTH;
        cur_max_body  = RESET_MAX_BODY;
        phase_bytes   = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(16'd0, STUN_COOKIE);
        send_frame(16'(CHAN_HDR), 32'h0000_0000);
        send_frame(16'd3, 32'hFFFF_FFFF);
        send_frame(16'd8, ~STUN_COOKIE);
        send_frame(16'd5, STUN_COOKIE ^ 32'h0000_0001);
        send_frame(16'hFFFF, STUN_COOKIE);
        phase_bytes = 0;
        send_random_frames();

        set_regs({11'($urandom), 5'd20}, 16'd4);
        calm <= 1'b1;
        send_frame(16'd8, 32'h0F0F_0F0F);
        send_frame(16'd9, 32'hF0F0_F0F0);

        calm <= 1'b0;
        set_regs(16'h0000, 16'h0000);
        send_frame(16'(CHAN_HDR), 32'hA5A5_A5A5);
        send_frame(16'd0, STUN_COOKIE);

        set_regs(16'hFFFF, 16'hFFFF);
        pressure_req <= 1'b1;
        send_frame(16'hFFFF, STUN_COOKIE);
        send_frame(16'd0, STUN_COOKIE);

        set_regs({11'($urandom), 5'($urandom_range(9, 19))}, 16'($urandom_range(16, 300)));
        send_random_frames();

        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_beats == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
